/* rtl/fde_pkg.sv */
// Package for the FAT directory entry matcher: status and register codes,
// directory entry constants and the short-name checksum step.
// No dependencies.
package fde_pkg;

   // Result status of one directory entry.
   typedef enum logic [1:0] {
      STATUS_CONTINUE = 2'd0,
      STATUS_MATCHED  = 2'd1,
      STATUS_END      = 2'd2,
      STATUS_IDLE     = 2'd3
   } search_status_type;

   // Register indexes of the configuration port.
   typedef enum logic [2:0] {
      CSR_NAME_LENGTH   = 3'd0,
      CSR_NAME_CHARS_0  = 3'd1,
      CSR_NAME_CHARS_8  = 3'd2,
      CSR_NAME_CHARS_16 = 3'd3,
      CSR_NAME_CHARS_24 = 3'd4
   } csr_index_type;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 64;
   localparam int NAME_LEN_WIDTH  = 6;

   // The name registers hold this many characters.
   localparam int NAME_REG_CHARS = 32;

   localparam int ENTRY_BYTES = 32;

   // Directory entry markers and fields.
   localparam logic [7:0] ENTRY_END_MARK     = 8'h00;
   localparam logic [7:0] ENTRY_DELETED_MARK = 8'h05;
   localparam logic [7:0] ENTRY_DELETED_ALT  = 8'hE5;
   localparam logic [3:0] LFN_ATTR_NIBBLE    = 4'hF;
   localparam logic [7:0] LFN_CHAR_NUL       = 8'h00;
   localparam logic [7:0] LFN_CHAR_FILL      = 8'hFF;
   localparam int         ATTR_BYTE          = 11;
   localparam int         LFN_CHECKSUM_BYTE  = 13;
   localparam int         LFN_SEQ_WIDTH      = 5;

   // Long-name entry: 13 character slots at these byte offsets.
   localparam int LFN_CHARS = 13;
   localparam int LFN_CHAR_POS [LFN_CHARS] = '{1, 3, 5, 7, 9, 14, 16, 18, 20, 22, 24, 28, 30};

   // Number of long-name sequence values that reach into the name registers.
   localparam int LFN_NAME_SLOTS = (NAME_REG_CHARS + LFN_CHARS - 1) / LFN_CHARS;

   // Short name: the checksum covers 11 bytes, the name compare up to 8.
   localparam int SFN_CHECKSUM_BYTES = 11;
   localparam int SFN_CHECKSUM_SPLIT = 6;
   localparam int SFN_NAME_BYTES     = 8;

   // ASCII case folding.
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   // One rotate-right-and-add step of the short-name checksum.
   function automatic logic [7:0] sfn_checksum_step(input logic [7:0] sum,
                                                    input logic [7:0] data);
      return {sum[0], sum[7:1]} + data;
   endfunction

endpackage

/* rtl/fat_directory_entry_matcher.sv */
// FAT directory entry matcher top level: request register, compare logic,
// search state and result register. Depends on fde_pkg.
//
// Usage:
//   The csr_ channel loads the name length (index 0) and the name characters
//   (indexes 1 to 4, lowest character in the lowest byte). It is always ready;
//   the user must write it only while no request is in flight (not enforced).
//   Each request on the req_ channel carries one 32-byte directory entry and
//   a new_search flag that clears the search state before that entry.
//   Every request yields exactly one result on the rsp_ channel: a status,
//   and on a match the start cluster and file size.
//   A request accepted is registered in the request register, its compare
//   runs from that register and the result is registered in the result
//   register. Throughput is one request per cycle while the receiver does
//   not stall, set by the single compare stage between the request register
//   and the result register; the search state updates as a request moves
//   into the result register, so the next request sees it at once.
//   When the receiver stalls, the result register holds and the request
//   register still takes one more request; req_ready falls only when both
//   are full.
//   Synchronous reset clears the name registers, the search state and both
//   valid flags. No clearing pass is needed.
module fat_directory_entry_matcher
   import fde_pkg::*;
#(
   parameter int NAME_MAX_CHARS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   // Configuration write channel.
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   // Request channel.
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_new_search,
   input  logic [63:0]                req_entry_bytes_0_7,
   input  logic [63:0]                req_entry_bytes_8_15,
   input  logic [63:0]                req_entry_bytes_16_23,
   input  logic [63:0]                req_entry_bytes_24_31,
   // Result channel.
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [1:0]                 rsp_search_status,
   output logic [31:0]                rsp_start_cluster,
   output logic [31:0]                rsp_file_size
);

   // Effective name length limit.
   localparam int NameLimit = (NAME_MAX_CHARS < NAME_REG_CHARS) ? NAME_MAX_CHARS
                                                                : NAME_REG_CHARS;
   localparam logic [NAME_LEN_WIDTH-1:0] NameLimitCode = NAME_LEN_WIDTH'(NameLimit);

   // Configuration registers.
   logic [NAME_LEN_WIDTH-1:0]   name_length_ff;
   logic [NAME_REG_CHARS*8-1:0] name_ff;
   logic [NAME_LEN_WIDTH-1:0]   eff_len;

   // Request register.
   logic                     s1_valid_ff;
   logic                     s1_new_search_ff;
   logic [ENTRY_BYTES*8-1:0] s1_entry_ff;
   logic [7:0]               s1_chk_part_ff;
   logic [7:0]               chk_part_in;

   // Search state.
   logic [7:0] lfn_sum_ff, lfn_sum_in;
   logic       lfn_match_ff, lfn_match_in;
   logic       lfn_seen_ff, lfn_seen_in;
   logic       finished_ff, finished_in;

   // Result register.
   logic              rsp_valid_ff;
   search_status_type rsp_status_ff, status_in;
   logic [31:0]       rsp_cluster_ff, cluster_in;
   logic [31:0]       rsp_size_ff, size_in;

   logic advance;

   // Compare results.
   logic       lfn_ok;
   logic       sfn_ok;
   logic [7:0] sfn_sum;

   assign csr_ready = 1'b1;
   assign eff_len   = (name_length_ff > NameLimitCode) ? NameLimitCode : name_length_ff;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         name_length_ff <= '0;
         name_ff        <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_NAME_LENGTH:   name_length_ff  <= csr_wdata[NAME_LEN_WIDTH-1:0];
            CSR_NAME_CHARS_0:  name_ff[63:0]   <= csr_wdata;
            CSR_NAME_CHARS_8:  name_ff[127:64] <= csr_wdata;
            CSR_NAME_CHARS_16: name_ff[191:128] <= csr_wdata;
            CSR_NAME_CHARS_24: name_ff[255:192] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Handshake: the compare stage moves on when the result register is free.
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   // First part of the short-name checksum, taken on the request bytes.
   always_comb begin
      chk_part_in = '0;
      for (int i = 0; i < SFN_CHECKSUM_SPLIT; i++) begin
         chk_part_in = sfn_checksum_step(chk_part_in, req_entry_bytes_0_7[8*i +: 8]);
      end
   end

   // Request register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_new_search_ff <= req_new_search;
         s1_entry_ff      <= {req_entry_bytes_24_31, req_entry_bytes_16_23,
                              req_entry_bytes_8_15, req_entry_bytes_0_7};
         s1_chk_part_ff   <= chk_part_in;
      end
   end

   // Long-name fragment compare: each slot against its name position,
   // stopping at the first NUL or fill character.
   always_comb begin
      logic                     term;
      logic [7:0]               c;
      logic [7:0]               n;
      logic [LFN_SEQ_WIDTH-1:0] seq;
      int                       pos;
      term   = 1'b0;
      lfn_ok = 1'b1;
      seq    = s1_entry_ff[LFN_SEQ_WIDTH-1:0];
      for (int i = 0; i < LFN_CHARS; i++) begin
         c = s1_entry_ff[8*LFN_CHAR_POS[i] +: 8];
         n = '0;
         for (int k = 0; k < LFN_NAME_SLOTS; k++) begin
            pos = LFN_CHARS * k + i;
            if (pos < NAME_REG_CHARS && seq == LFN_SEQ_WIDTH'(k + 1) &&
                NAME_LEN_WIDTH'(pos) < eff_len) begin
               n = name_ff[8*(pos % NAME_REG_CHARS) +: 8];
            end
         end
         if (!term) begin
            if (c == LFN_CHAR_NUL || c == LFN_CHAR_FILL) begin
               term = 1'b1;
            end else if (c != n) begin
               lfn_ok = 1'b0;
            end
         end
      end
   end

   // Short-name compare against the upper-cased name, and the rest of the
   // checksum.
   always_comb begin
      logic [7:0] c;
      sfn_ok  = 1'b1;
      sfn_sum = s1_chk_part_ff;
      for (int i = 0; i < SFN_NAME_BYTES; i++) begin
         c = name_ff[8*i +: 8];
         if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            c = c - CASE_OFFSET;
         end
         if (NAME_LEN_WIDTH'(i) < eff_len && c != s1_entry_ff[8*i +: 8]) begin
            sfn_ok = 1'b0;
         end
      end
      for (int i = SFN_CHECKSUM_SPLIT; i < SFN_CHECKSUM_BYTES; i++) begin
         sfn_sum = sfn_checksum_step(sfn_sum, s1_entry_ff[8*i +: 8]);
      end
   end

   // Entry decision and next search state.
   always_comb begin
      logic [7:0] first;
      logic [7:0] attr;
      logic       hit;
      first = s1_entry_ff[7:0];
      attr  = s1_entry_ff[8*ATTR_BYTE +: 8];
      hit   = 1'b0;

      lfn_sum_in   = s1_new_search_ff ? 8'h00 : lfn_sum_ff;
      lfn_match_in = s1_new_search_ff ? 1'b1  : lfn_match_ff;
      lfn_seen_in  = s1_new_search_ff ? 1'b0  : lfn_seen_ff;
      finished_in  = s1_new_search_ff ? 1'b0  : finished_ff;

      status_in  = STATUS_CONTINUE;
      cluster_in = '0;
      size_in    = '0;

      if (finished_in) begin
         status_in = STATUS_IDLE;
      end else if (first == ENTRY_END_MARK) begin
         status_in   = STATUS_END;
         finished_in = 1'b1;
      end else if (first == ENTRY_DELETED_MARK || first == ENTRY_DELETED_ALT) begin
         status_in = STATUS_CONTINUE;
      end else if (attr[3:0] == LFN_ATTR_NIBBLE) begin
         if (!lfn_ok) begin
            lfn_match_in = 1'b0;
         end
         lfn_sum_in  = s1_entry_ff[8*LFN_CHECKSUM_BYTE +: 8];
         lfn_seen_in = 1'b1;
      end else begin
         if (lfn_seen_in && lfn_match_in) begin
            hit = (lfn_sum_in == sfn_sum);
         end else begin
            hit = sfn_ok;
         end
         if (eff_len == '0) begin
            hit = 1'b0;
         end
         if (hit) begin
            status_in   = STATUS_MATCHED;
            cluster_in  = {s1_entry_ff[8*21 +: 8], s1_entry_ff[8*20 +: 8],
                           s1_entry_ff[8*27 +: 8], s1_entry_ff[8*26 +: 8]};
            size_in     = s1_entry_ff[8*28 +: 32];
            finished_in = 1'b1;
         end
         lfn_match_in = 1'b1;
         lfn_sum_in   = 8'h00;
         lfn_seen_in  = 1'b0;
      end
   end

   // Search state, updated as an entry moves into the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         lfn_sum_ff   <= 8'h00;
         lfn_match_ff <= 1'b1;
         lfn_seen_ff  <= 1'b0;
         finished_ff  <= 1'b0;
      end else if (advance) begin
         lfn_sum_ff   <= lfn_sum_in;
         lfn_match_ff <= lfn_match_in;
         lfn_seen_ff  <= lfn_seen_in;
         finished_ff  <= finished_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_status_ff  <= status_in;
         rsp_cluster_ff <= cluster_in;
         rsp_size_ff    <= size_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_search_status = rsp_status_ff;
   assign rsp_start_cluster = rsp_cluster_ff;
   assign rsp_file_size     = rsp_size_ff;

   // A result that is not a match carries no cluster and no size.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != STATUS_MATCHED
      |-> rsp_cluster_ff == '0 && rsp_size_ff == '0)
      else $error("non-matching result carries cluster or size");

   // A match or an end marker leaves the search finished.
   assert property (@(posedge clock) disable iff (reset)
      advance && (status_in == STATUS_MATCHED || status_in == STATUS_END)
      |=> finished_ff)
      else $error("search not finished after match or end");

   // Idle status only comes from a finished search without a new search.
   assert property (@(posedge clock) disable iff (reset)
      advance && status_in == STATUS_IDLE |-> finished_ff && !s1_new_search_ff)
      else $error("idle status without a finished search");

   // Requests are refused only when both registers are full and stalled.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_valid_ff && rsp_valid_ff && !rsp_ready)
      else $error("request refused while a register is free");

endmodule
